[src/priority_ready_queue_defines.svh]
// Assertion macros shared by the priority ready queue RTL.
`ifndef PRIORITY_READY_QUEUE_DEFINES_SVH
`define PRIORITY_READY_QUEUE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PRQ_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PRQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/prq_pkg.sv]
// Shared types and codes of the priority ready queue.
package prq_pkg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LINK,
        S_FIX,
        S_DONE
    } t_state;

    typedef enum logic {
        OP_APPEND = 1'b0,
        OP_REMOVE = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_DUP_APPEND = 2'd1,
        ST_NOT_QUEUED = 2'd2,
        ST_BAD_INDEX  = 2'd3
    } t_status;

    // Field write enables of the task table.
    typedef struct packed {
        logic next;
        logic prev;
        logic level;
    } t_task_we;

    // Field write enables of the level table.
    typedef struct packed {
        logic head;
        logic tail;
    } t_lvl_we;

endpackage

[src/priority_ready_queue.sv]
// Top level of the priority ready queue: sequencer over the task and level tables.
// An accepted request steps through link, fix and done, a rejected one through fix and
// done only; done holds while the previous result still waits in the output register.
// No new request is taken before done ends; the two task table link writes and the
// registered head read of the level table set these steps. Reset (synchronous, active
// low) clears the sequencer, queued flags, level mask and output valid, not the tables.
`include "priority_ready_queue_defines.svh"

module priority_ready_queue
    import prq_pkg::*;
#(
    parameter int NUM_TASKS  = 8,
    parameter int NUM_LEVELS = 10
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_opcode,
    input  logic [2:0] i_task_index,
    input  logic [3:0] i_task_priority,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [2:0] o_top_task,
    output logic       o_any_ready,
    output logic [1:0] o_status
);

    localparam int IW = $clog2(NUM_TASKS);
    localparam int LW = $clog2(NUM_TASKS + 1);
    localparam int VW = $clog2(NUM_LEVELS);

    // A link equal to the task count marks the end of a list.
    localparam logic [LW-1:0] NIL     = LW'(NUM_TASKS);
    localparam logic [VW-1:0] LVL_MAX = VW'(NUM_LEVELS - 1);

    // The most urgent level that holds at least one task.
    function automatic logic [VW-1:0] first_level(input logic [NUM_LEVELS-1:0] mask);
        logic [VW-1:0] lvl;
        lvl = '0;
        for (int k = NUM_LEVELS - 1; k >= 0; k--) begin
            if (mask[k]) begin
                lvl = VW'(k);
            end
        end
        return lvl;
    endfunction

    // Sequencer and per-request registers.
    t_state                r_state, n_state;
    t_opcode               r_op, n_op;
    t_status               r_status, n_status;
    logic [IW-1:0]         r_idx, n_idx;
    logic [VW-1:0]         r_lvl, n_lvl;

    // One queued flag per task and one non-empty flag per level.
    logic [NUM_TASKS-1:0]  r_queued, n_queued;
    logic [NUM_LEVELS-1:0] r_nonempty, n_nonempty;

    // Second link write, held over from the link step to the fix step.
    t_task_we              r_fix_we, n_fix_we;
    logic [IW-1:0]         r_fix_addr, n_fix_addr;
    logic [LW-1:0]         r_fix_link, n_fix_link;

    // Output register.
    logic                  r_o_valid, n_o_valid;
    logic [2:0]            r_o_top, n_o_top;
    logic                  r_o_any, n_o_any;
    logic [1:0]            r_o_status, n_o_status;

    // Table ports.
    t_task_we              task_we;
    logic [IW-1:0]         task_waddr;
    logic [LW-1:0]         task_next_wr;
    logic [LW-1:0]         task_prev_wr;
    logic [VW-1:0]         task_level_wr;
    logic                  task_re;
    logic [IW-1:0]         task_raddr;
    logic [LW-1:0]         task_next_rd;
    logic [LW-1:0]         task_prev_rd;
    logic [VW-1:0]         task_level_rd;
    t_lvl_we               lvl_we;
    logic [VW-1:0]         lvl_waddr;
    logic [LW-1:0]         lvl_head_wr;
    logic [LW-1:0]         lvl_tail_wr;
    logic                  lvl_re;
    logic [VW-1:0]         lvl_raddr;
    logic [LW-1:0]         lvl_head_rd;
    logic [LW-1:0]         lvl_tail_rd;

    // Request decode.
    logic                  in_fire;
    logic                  idx_ok;
    logic [IW-1:0]         in_idx;
    logic [VW-1:0]         in_lvl;
    logic                  tail_live;
    logic                  prev_live;
    logic                  next_live;

    prq_tables #(
        .NUM_TASKS  (NUM_TASKS),
        .NUM_LEVELS (NUM_LEVELS)
    ) u_tables (
        .i_clk        (i_clk),
        .i_task_we    (task_we),
        .i_task_waddr (task_waddr),
        .i_task_next  (task_next_wr),
        .i_task_prev  (task_prev_wr),
        .i_task_level (task_level_wr),
        .i_task_re    (task_re),
        .i_task_raddr (task_raddr),
        .o_task_next  (task_next_rd),
        .o_task_prev  (task_prev_rd),
        .o_task_level (task_level_rd),
        .i_lvl_we     (lvl_we),
        .i_lvl_waddr  (lvl_waddr),
        .i_lvl_head   (lvl_head_wr),
        .i_lvl_tail   (lvl_tail_wr),
        .i_lvl_re     (lvl_re),
        .i_lvl_raddr  (lvl_raddr),
        .o_lvl_head   (lvl_head_rd),
        .o_lvl_tail   (lvl_tail_rd)
    );

    // The block takes a request only when the sequencer is free. The output register
    // parts the two sides, so a waiting result does not hold off the next request.
    assign o_ready = (r_state == S_IDLE);
    assign in_fire = i_valid && o_ready;

    // Indexes beyond the task count are rejected; priorities beyond the last level
    // saturate to the least urgent level.
    assign idx_ok = (32'(i_task_index) < NUM_TASKS);
    assign in_idx = IW'(i_task_index);
    assign in_lvl = (32'(i_task_priority) >= NUM_LEVELS) ? LVL_MAX : VW'(i_task_priority);

    // The appended task's level is live when its non-empty flag is set; a removed
    // task's neighbors are live when their links are not the end marker.
    assign tail_live = r_nonempty[r_lvl];
    assign prev_live = (task_prev_rd != NIL);
    assign next_live = (task_next_rd != NIL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_queued   <= '0;
            r_nonempty <= '0;
            r_o_valid  <= 1'b0;
            r_fix_we   <= '0;
        end else begin
            r_state    <= n_state;
            r_queued   <= n_queued;
            r_nonempty <= n_nonempty;
            r_o_valid  <= n_o_valid;
            r_fix_we   <= n_fix_we;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_status   <= n_status;
        r_idx      <= n_idx;
        r_lvl      <= n_lvl;
        r_fix_addr <= n_fix_addr;
        r_fix_link <= n_fix_link;
        r_o_top    <= n_o_top;
        r_o_any    <= n_o_any;
        r_o_status <= n_o_status;
    end

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_status   = r_status;
        n_idx      = r_idx;
        n_lvl      = r_lvl;
        n_queued   = r_queued;
        n_nonempty = r_nonempty;
        n_fix_we   = r_fix_we;
        n_fix_addr = r_fix_addr;
        n_fix_link = r_fix_link;
        n_o_top    = r_o_top;
        n_o_any    = r_o_any;
        n_o_status = r_o_status;
        n_o_valid  = r_o_valid && !i_ready;

        task_we       = '0;
        task_waddr    = r_idx;
        task_next_wr  = NIL;
        task_prev_wr  = NIL;
        task_level_wr = r_lvl;
        task_re       = 1'b0;
        task_raddr    = in_idx;
        lvl_we        = '0;
        lvl_waddr     = r_lvl;
        lvl_head_wr   = LW'(r_idx);
        lvl_tail_wr   = LW'(r_idx);
        lvl_re        = 1'b0;
        lvl_raddr     = in_lvl;

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_op  = t_opcode'(i_opcode);
                    n_idx = in_idx;
                    n_lvl = in_lvl;
                    if (!idx_ok) begin
                        n_status = ST_BAD_INDEX;
                    end else if ((i_opcode == OP_APPEND) && r_queued[in_idx]) begin
                        n_status = ST_DUP_APPEND;
                    end else if ((i_opcode == OP_REMOVE) && !r_queued[in_idx]) begin
                        n_status = ST_NOT_QUEUED;
                    end else begin
                        n_status = ST_OK;
                    end
                    n_fix_we = '0;
                    if (n_status == ST_OK) begin
                        // Append needs the level's tail, remove needs the task's links.
                        lvl_re  = (i_opcode == OP_APPEND);
                        task_re = (i_opcode == OP_REMOVE);
                        n_state = S_LINK;
                    end else begin
                        n_state = S_FIX;
                    end
                end
            end

            S_LINK: begin
                if (r_op == OP_APPEND) begin
                    // The new task becomes the tail; the old tail, if any, gets a
                    // forward link in the fix step.
                    task_we       = '{next: 1'b1, prev: 1'b1, level: 1'b1};
                    task_waddr    = r_idx;
                    task_next_wr  = NIL;
                    task_prev_wr  = tail_live ? lvl_tail_rd : NIL;
                    task_level_wr = r_lvl;
                    lvl_we        = '{head: !tail_live, tail: 1'b1};
                    lvl_waddr     = r_lvl;
                    lvl_head_wr   = LW'(r_idx);
                    lvl_tail_wr   = LW'(r_idx);
                    n_queued[r_idx]   = 1'b1;
                    n_nonempty[r_lvl] = 1'b1;
                    n_fix_we   = '{next: tail_live, prev: 1'b0, level: 1'b0};
                    n_fix_addr = IW'(lvl_tail_rd);
                    n_fix_link = LW'(r_idx);
                end else begin
                    // Unlink: the predecessor's forward link or the list head moves
                    // now, the successor's back link in the fix step.
                    task_we      = '{next: prev_live, prev: 1'b0, level: 1'b0};
                    task_waddr   = IW'(task_prev_rd);
                    task_next_wr = task_next_rd;
                    lvl_we       = '{head: !prev_live, tail: !next_live};
                    lvl_waddr    = task_level_rd;
                    lvl_head_wr  = task_next_rd;
                    lvl_tail_wr  = task_prev_rd;
                    n_queued[r_idx] = 1'b0;
                    if (!prev_live && !next_live) begin
                        n_nonempty[task_level_rd] = 1'b0;
                    end
                    n_fix_we   = '{next: 1'b0, prev: next_live, level: 1'b0};
                    n_fix_addr = IW'(task_next_rd);
                    n_fix_link = task_prev_rd;
                end
                n_state = S_FIX;
            end

            S_FIX: begin
                task_we      = r_fix_we;
                task_waddr   = r_fix_addr;
                task_next_wr = r_fix_link;
                task_prev_wr = r_fix_link;
                // The level table was last written in the link step, so this read
                // already sees the updated head.
                lvl_re    = 1'b1;
                lvl_raddr = first_level(r_nonempty);
                n_state   = S_DONE;
            end

            S_DONE: begin
                if (!r_o_valid || i_ready) begin
                    n_o_valid  = 1'b1;
                    n_o_any    = |r_nonempty;
                    n_o_top    = (|r_nonempty) ? 3'(lvl_head_rd) : 3'd0;
                    n_o_status = r_status;
                    n_state    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_valid     = r_o_valid;
    assign o_top_task  = r_o_top;
    assign o_any_ready = r_o_any;
    assign o_status    = r_o_status;

    `PRQ_ASSERT_NEXT(a_fire_starts_work, i_clk, i_rst_n, in_fire,
        r_state == S_LINK || r_state == S_FIX,
        "accepted request did not start the sequencer")
    `PRQ_ASSERT_NEXT(a_append_sets_flag, i_clk, i_rst_n,
        r_state == S_LINK && r_op == OP_APPEND, r_queued[r_idx],
        "append did not mark the task as queued")
    `PRQ_ASSERT_SAME(a_levels_le_tasks, i_clk, i_rst_n, 1'b1,
        $countones(r_nonempty) <= $countones(r_queued),
        "more non-empty levels than queued tasks")
    `PRQ_ASSERT_SAME(a_result_from_done, i_clk, i_rst_n, $rose(r_o_valid),
        $past(r_state) == S_DONE,
        "result appeared outside the completion step")

endmodule

[src/prq_tables.sv]
// Task link table and per-level head/tail table, both with registered reads.
module prq_tables
    import prq_pkg::*;
#(
    parameter int NUM_TASKS  = 8,
    parameter int NUM_LEVELS = 10
) (
    input  logic                          i_clk,
    input  t_task_we                      i_task_we,
    input  logic [$clog2(NUM_TASKS)-1:0]  i_task_waddr,
    input  logic [$clog2(NUM_TASKS+1)-1:0] i_task_next,
    input  logic [$clog2(NUM_TASKS+1)-1:0] i_task_prev,
    input  logic [$clog2(NUM_LEVELS)-1:0] i_task_level,
    input  logic                          i_task_re,
    input  logic [$clog2(NUM_TASKS)-1:0]  i_task_raddr,
    output logic [$clog2(NUM_TASKS+1)-1:0] o_task_next,
    output logic [$clog2(NUM_TASKS+1)-1:0] o_task_prev,
    output logic [$clog2(NUM_LEVELS)-1:0] o_task_level,
    input  t_lvl_we                       i_lvl_we,
    input  logic [$clog2(NUM_LEVELS)-1:0] i_lvl_waddr,
    input  logic [$clog2(NUM_TASKS+1)-1:0] i_lvl_head,
    input  logic [$clog2(NUM_TASKS+1)-1:0] i_lvl_tail,
    input  logic                          i_lvl_re,
    input  logic [$clog2(NUM_LEVELS)-1:0] i_lvl_raddr,
    output logic [$clog2(NUM_TASKS+1)-1:0] o_lvl_head,
    output logic [$clog2(NUM_TASKS+1)-1:0] o_lvl_tail
);

    localparam int LW = $clog2(NUM_TASKS + 1);
    localparam int VW = $clog2(NUM_LEVELS);

    // Task entry layout: {next, prev, level}.
    localparam int T_LVL_LO  = 0;
    localparam int T_PREV_LO = VW;
    localparam int T_NEXT_LO = VW + LW;
    localparam int TEW       = VW + 2 * LW;

    // Level entry layout: {head, tail}.
    localparam int L_TAIL_LO = 0;
    localparam int L_HEAD_LO = LW;
    localparam int LEW       = 2 * LW;

    logic [TEW-1:0] r_task_mem [NUM_TASKS];
    logic [LEW-1:0] r_lvl_mem  [NUM_LEVELS];
    logic [TEW-1:0] r_task_rd;
    logic [LEW-1:0] r_lvl_rd;

    always_ff @(posedge i_clk) begin
        if (i_task_we.next) begin
            r_task_mem[i_task_waddr][T_NEXT_LO +: LW] <= i_task_next;
        end
        if (i_task_we.prev) begin
            r_task_mem[i_task_waddr][T_PREV_LO +: LW] <= i_task_prev;
        end
        if (i_task_we.level) begin
            r_task_mem[i_task_waddr][T_LVL_LO +: VW] <= i_task_level;
        end
        if (i_task_re) begin
            r_task_rd <= r_task_mem[i_task_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_lvl_we.head) begin
            r_lvl_mem[i_lvl_waddr][L_HEAD_LO +: LW] <= i_lvl_head;
        end
        if (i_lvl_we.tail) begin
            r_lvl_mem[i_lvl_waddr][L_TAIL_LO +: LW] <= i_lvl_tail;
        end
        if (i_lvl_re) begin
            r_lvl_rd <= r_lvl_mem[i_lvl_raddr];
        end
    end

    assign o_task_next  = r_task_rd[T_NEXT_LO +: LW];
    assign o_task_prev  = r_task_rd[T_PREV_LO +: LW];
    assign o_task_level = r_task_rd[T_LVL_LO +: VW];
    assign o_lvl_head   = r_lvl_rd[L_HEAD_LO +: LW];
    assign o_lvl_tail   = r_lvl_rd[L_TAIL_LO +: LW];

endmodule

[bench/prq_checker.sv]
// Scoreboard for the priority ready queue: predicts each response and compares it.
module prq_checker
    import prq_pkg::*;
#(
    parameter int NUM_TASKS  = 8,
    parameter int NUM_LEVELS = 10
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_req_valid,
    input  logic       i_req_ready,
    input  logic       i_opcode,
    input  logic [2:0] i_task_index,
    input  logic [3:0] i_task_priority,
    input  logic       i_rsp_valid,
    input  logic       i_rsp_ready,
    input  logic [2:0] i_top_task,
    input  logic       i_any_ready,
    input  logic [1:0] i_status,
    output int         o_mismatches,
    output int         o_outstanding
);

    localparam int LINK_W = $clog2(NUM_TASKS + 1);
    localparam logic [LINK_W-1:0] NIL = LINK_W'(NUM_TASKS);

    typedef struct packed {
        logic [2:0] top;
        logic       any;
        t_status    status;
    } t_sched_view;

    // Shadow copy of the linked lists.
    logic [LINK_W-1:0] succ_link [NUM_TASKS];
    logic [LINK_W-1:0] pred_link [NUM_TASKS];
    logic              is_linked [NUM_TASKS];
    logic [3:0]        task_lvl  [NUM_TASKS];
    logic [LINK_W-1:0] lvl_head  [NUM_LEVELS];
    logic [LINK_W-1:0] lvl_tail  [NUM_LEVELS];

    t_sched_view results_due [$];

    initial begin
        o_mismatches  = 0;
        o_outstanding = 0;
    end

    // Applies one request to the shadow lists and returns the view reported after it.
    function automatic t_sched_view apply_request(logic op, logic [2:0] idx,
                                                  logic [3:0] pri);
        t_sched_view view;
        int lvl;
        int t;
        logic [LINK_W-1:0] p;
        logic [LINK_W-1:0] n;
        lvl = (pri >= NUM_LEVELS) ? NUM_LEVELS - 1 : int'(pri);
        t = int'(idx);
        view.status = ST_OK;
        if (t >= NUM_TASKS) begin
            view.status = ST_BAD_INDEX;
        end else if (op == OP_APPEND) begin
            if (is_linked[t]) begin
                view.status = ST_DUP_APPEND;
            end else begin
                p = lvl_tail[lvl];
                task_lvl[t]  = 4'(lvl);
                is_linked[t] = 1'b1;
                succ_link[t] = NIL;
                pred_link[t] = p;
                if (p != NIL) begin
                    succ_link[p] = LINK_W'(t);
                end else begin
                    lvl_head[lvl] = LINK_W'(t);
                end
                lvl_tail[lvl] = LINK_W'(t);
            end
        end else begin
            if (!is_linked[t]) begin
                view.status = ST_NOT_QUEUED;
            end else begin
                lvl = (task_lvl[t] >= NUM_LEVELS) ? NUM_LEVELS - 1 : int'(task_lvl[t]);
                p = pred_link[t];
                n = succ_link[t];
                // Unlinking an end of the list moves that list's head or tail instead.
                if (p != NIL) begin
                    succ_link[p] = n;
                end else begin
                    lvl_head[lvl] = n;
                end
                if (n != NIL) begin
                    pred_link[n] = p;
                end else begin
                    lvl_tail[lvl] = p;
                end
                pred_link[t] = NIL;
                succ_link[t] = NIL;
                is_linked[t] = 1'b0;
            end
        end
        view.top = 3'd0;
        view.any = 1'b0;
        for (int k = NUM_LEVELS - 1; k >= 0; k--) begin
            if (lvl_head[k] != NIL) begin
                view.top = 3'(lvl_head[k]);
                view.any = 1'b1;
            end
        end
        return view;
    endfunction

    always @(posedge i_clk) begin : track
        t_sched_view want;
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_TASKS; k++) begin
                succ_link[k] = NIL;
                pred_link[k] = NIL;
                is_linked[k] = 1'b0;
                task_lvl[k]  = 4'd0;
            end
            for (int k = 0; k < NUM_LEVELS; k++) begin
                lvl_head[k] = NIL;
                lvl_tail[k] = NIL;
            end
            results_due.delete();
        end else begin
            if (i_rsp_valid && i_rsp_ready) begin
                if (results_due.size() == 0) begin
                    $error("response with no request outstanding");
                    o_mismatches++;
                end else begin
                    want = results_due.pop_front();
                    if (i_top_task !== want.top) begin
                        $error("top_task: expected %0d, got %0d", want.top, i_top_task);
                        o_mismatches++;
                    end
                    if (i_any_ready !== want.any) begin
                        $error("any_ready: expected %0d, got %0d", want.any, i_any_ready);
                        o_mismatches++;
                    end
                    if (i_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_status);
                        o_mismatches++;
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                results_due.push_back(apply_request(i_opcode, i_task_index,
                                                    i_task_priority));
            end
        end
        o_outstanding = results_due.size();
    end

endmodule

[bench/tb.sv]
// Testbench top for the priority ready queue: stimulus, flow control and verdict.
module tb
    import prq_pkg::*;
();

    localparam int RANDOM_PER_PHASE = 650;
    localparam int HOLD_CYCLES      = 300;
    localparam int IDLE_LIMIT       = 4000;
    localparam int DRAIN_CYCLES     = 8;

    logic       i_clk           = 1'b0;
    logic       i_rst_n         = 1'b0;
    logic       i_valid         = 1'b0;
    logic       i_opcode        = 1'b0;
    logic [2:0] i_task_index    = 3'd0;
    logic [3:0] i_task_priority = 4'd0;
    logic       i_ready         = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [2:0] o_top_task;
    logic       o_any_ready;
    logic [1:0] o_status;

    int mismatch_count;
    int outstanding;

    // Percent chance per cycle that the sender or the receiver sits idle.
    int send_gap_pct = 7;
    int recv_gap_pct = 81;

    // Receiver hold-off: requested once by the stimulus, counted down by the receiver.
    bit hold_req  = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;

    // Which tasks the stimulus believes are queued; used only to shape requests.
    logic [7:0] queued_mask = 8'd0;

    int idle_cycles = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    priority_ready_queue u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_opcode        (i_opcode),
        .i_task_index    (i_task_index),
        .i_task_priority (i_task_priority),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_top_task      (o_top_task),
        .o_any_ready     (o_any_ready),
        .o_status        (o_status)
    );

    prq_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_valid     (i_valid),
        .i_req_ready     (o_ready),
        .i_opcode        (i_opcode),
        .i_task_index    (i_task_index),
        .i_task_priority (i_task_priority),
        .i_rsp_valid     (o_valid),
        .i_rsp_ready     (i_ready),
        .i_top_task      (o_top_task),
        .i_any_ready     (o_any_ready),
        .i_status        (o_status),
        .o_mismatches    (mismatch_count),
        .o_outstanding   (outstanding)
    );

    // Receiver: random back-pressure, or a long hold-off once so the block backs up.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            i_ready   <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_gap_pct);
        end
    end

    // Watchdog: a long run of cycles with no handshake on either side means a hang.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("priority_ready_queue test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offers one request, waits for it to be taken, then maybe idles the sender.
    // Valid stays high into the next request when no gap is drawn.
    task automatic offer_request(input logic op, input logic [2:0] idx,
                                 input logic [3:0] pri);
        i_opcode        <= op;
        i_task_index    <= idx;
        i_task_priority <= pri;
        i_valid         <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        queued_mask[idx] = (op == OP_APPEND);
        if ($urandom_range(99) < send_gap_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_gap_pct);
        end
    endtask

    // Mostly legal traffic: append idle tasks, remove queued ones from any position.
    // A small share is noise, which covers double appends and stray removes.
    task automatic random_request();
        int pick;
        logic [2:0] idx;
        logic [3:0] pri;
        logic op;
        pick = $urandom_range(99);
        if (pick < 8) begin
            offer_request(1'($urandom_range(1)), 3'($urandom_range(7)),
                          4'($urandom_range(15)));
        end else begin
            if (queued_mask == 8'hff) begin
                op = OP_REMOVE;
            end else if (queued_mask == 8'h00) begin
                op = OP_APPEND;
            end else begin
                op = ($urandom_range(99) < 55) ? OP_APPEND : OP_REMOVE;
            end
            do idx = 3'($urandom_range(7));
            while (queued_mask[idx] != (op == OP_REMOVE));
            // Few levels most of the time, so lists grow long and FIFO order matters.
            pick = $urandom_range(99);
            if (pick < 70) begin
                pri = 4'($urandom_range(3));
            end else if (pick < 90) begin
                pri = 4'($urandom_range(9));
            end else begin
                pri = 4'($urandom_range(15, 10));
            end
            offer_request(op, idx, pri);
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty queue, saturated priorities, duplicates, and unlinking
        // from the middle, the tail and the head of a list.
        offer_request(OP_REMOVE, 3'd0, 4'd0);
        offer_request(OP_APPEND, 3'd7, 4'd15);
        offer_request(OP_APPEND, 3'd0, 4'd0);
        offer_request(OP_APPEND, 3'd0, 4'd5);
        offer_request(OP_APPEND, 3'd3, 4'd0);
        offer_request(OP_APPEND, 3'd5, 4'd0);
        offer_request(OP_REMOVE, 3'd3, 4'd15);
        offer_request(OP_REMOVE, 3'd5, 4'd0);
        offer_request(OP_REMOVE, 3'd0, 4'd0);
        offer_request(OP_APPEND, 3'd1, 4'd9);
        offer_request(OP_APPEND, 3'd2, 4'd12);
        offer_request(OP_REMOVE, 3'd7, 4'd0);
        offer_request(OP_REMOVE, 3'd1, 4'd0);
        offer_request(OP_REMOVE, 3'd2, 4'd0);
        offer_request(OP_REMOVE, 3'd2, 4'd0);
        offer_request(OP_APPEND, 3'd4, 4'd10);
        offer_request(OP_APPEND, 3'd6, 4'd8);
        offer_request(OP_APPEND, 3'd3, 4'd8);
        offer_request(OP_REMOVE, 3'd6, 4'd0);
        offer_request(OP_REMOVE, 3'd4, 4'd0);
        offer_request(OP_REMOVE, 3'd3, 4'd0);

        // Sender mostly busy, receiver mostly stalling.
        repeat (RANDOM_PER_PHASE) random_request();

        // Sender mostly idle, receiver mostly ready.
        send_gap_pct = 81;
        recv_gap_pct = 7;
        repeat (RANDOM_PER_PHASE) random_request();

        // No idling, except one long receiver hold-off right at the start so the
        // block fills and must stall its request side.
        send_gap_pct = 0;
        recv_gap_pct = 0;
        hold_req    <= 1'b1;
        repeat (RANDOM_PER_PHASE) random_request();

        i_valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("priority_ready_queue test passed");
        end else begin
            $display("priority_ready_queue test failed");
        end
        $finish;
    end

endmodule
